### hdl/tsq_pkg.sv
package tsq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int WORD_W        = 32;
  localparam int STATUS_W      = 2;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Per-cycle request to one stack.
  typedef struct packed {
    logic push;
    logic pop;
  } lifo_req_t;

  // Occupancy flags reported by one stack.
  typedef struct packed {
    logic empty;
    logic full;
  } lifo_stat_t;

endpackage

### hdl/tsq_lifo.sv
module tsq_lifo #(
  parameter int DEPTH = tsq_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tsq_pkg::lifo_req_t          req,
  input  logic [tsq_pkg::WORD_W-1:0]  wr_data,
  output logic [tsq_pkg::WORD_W-1:0]  rd_data,
  output tsq_pkg::lifo_stat_t         stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [tsq_pkg::WORD_W-1:0] mem [DEPTH];
  logic [CW-1:0]              count;
  logic [CW-1:0]              count_dec;

  assign count_dec  = count - CW'(1);
  assign stat.empty = (count == '0);
  assign stat.full  = (count == CW'(DEPTH));

  // The top entry sits one below the count; a pop returns it through the rd_data register.
  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[count[AW-1:0]] <= wr_data;
    end
    if (req.pop) begin
      rd_data <= mem[count_dec[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (req.push) begin
      count <= count + CW'(1);
    end else if (req.pop) begin
      count <= count_dec;
    end
  end

endmodule

### hdl/tsq_ctrl.sv
module tsq_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [tsq_pkg::WORD_W-1:0]    s_tdata,   // [31:0] value
  input  logic                          s_tuser,   // [0] action
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tsq_pkg::WORD_W-1:0]    m_tdata,   // [31:0] data_out
  output logic [tsq_pkg::STATUS_W-1:0]  m_tuser,   // [1:0] status
  output tsq_pkg::lifo_req_t            in_req,
  output logic [tsq_pkg::WORD_W-1:0]    in_wdata,
  input  tsq_pkg::lifo_stat_t           in_stat,
  output tsq_pkg::lifo_req_t            out_req,
  input  tsq_pkg::lifo_stat_t           out_stat,
  input  logic [tsq_pkg::WORD_W-1:0]    out_rdata
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_XFER_RD  = 7'b0000010,
    S_XFER_WR  = 7'b0000100,
    S_PUSH     = 7'b0001000,
    S_POP_CHK  = 7'b0010000,
    S_POP_WAIT = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t                     state;
  logic                       action;
  logic [tsq_pkg::WORD_W-1:0] value;
  logic [tsq_pkg::WORD_W-1:0] res_data;
  tsq_pkg::status_t           res_status;
  logic                       xfer_go;

  assign s_tready = (state == S_IDLE);
  assign in_wdata = value;
  assign xfer_go  = !in_stat.empty && !out_stat.full;

  always_comb begin
    in_req  = '{push: (state == S_PUSH), pop: (state == S_XFER_RD) && xfer_go};
    out_req = '{push: (state == S_XFER_WR),
                pop:  (state == S_POP_CHK) && !out_stat.empty};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            action   <= s_tuser;
            value    <= s_tdata;
            res_data <= '0;
            if (s_tuser == tsq_pkg::ACT_PUSH) begin
              if (!in_stat.full) begin
                res_status <= tsq_pkg::ST_OK;
                state      <= S_PUSH;
              end else if (!out_stat.empty) begin
                res_status <= tsq_pkg::ST_FULL;
                state      <= S_DONE;
              end else begin
                res_status <= tsq_pkg::ST_OK;
                state      <= S_XFER_RD;
              end
            end else begin
              res_status <= tsq_pkg::ST_OK;
              state      <= out_stat.empty ? S_XFER_RD : S_POP_CHK;
            end
          end
        end
        // Move the inbox over one word at a time until it is empty or the outbox is full.
        S_XFER_RD: begin
          if (xfer_go) begin
            state <= S_XFER_WR;
          end else if (action == tsq_pkg::ACT_POP) begin
            state <= S_POP_CHK;
          end else begin
            state <= S_PUSH;
          end
        end
        S_XFER_WR: begin
          state <= S_XFER_RD;
        end
        S_PUSH: begin
          state <= S_DONE;
        end
        S_POP_CHK: begin
          if (out_stat.empty) begin
            res_status <= tsq_pkg::ST_EMPTY;
            state      <= S_DONE;
          end else begin
            state <= S_POP_WAIT;
          end
        end
        S_POP_WAIT: begin
          res_data <= out_rdata;
          state    <= S_DONE;
        end
        S_DONE: begin
          // Hold the result here until the output register is free.
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res_data;
            m_tuser  <= res_status;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/two_stack_queue.sv
// A push that needs no move runs S_PUSH then S_DONE; a pop whose outbox holds data
// runs S_POP_CHK, S_POP_WAIT, S_DONE; a move pairs S_XFER_RD and S_XFER_WR per word.
// Throughput: one request at a time through the shared stack sequencer; a new request
// is taken while a finished result still waits in the output register.
// Reset (rst, synchronous, active high) empties both stacks and drops any pending
// result; the stack memories keep their contents and need no clearing pass.
module two_stack_queue #(
  parameter int DEPTH = tsq_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [tsq_pkg::WORD_W-1:0]    s_tdata,   // [31:0] value
  input  logic                          s_tuser,   // [0] action
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tsq_pkg::WORD_W-1:0]    m_tdata,   // [31:0] data_out
  output logic [tsq_pkg::STATUS_W-1:0]  m_tuser    // [1:0] status
);

  tsq_pkg::lifo_req_t         in_req;
  tsq_pkg::lifo_req_t         out_req;
  tsq_pkg::lifo_stat_t        in_stat;
  tsq_pkg::lifo_stat_t        out_stat;
  logic [tsq_pkg::WORD_W-1:0] in_wdata;
  logic [tsq_pkg::WORD_W-1:0] in_rdata;
  logic [tsq_pkg::WORD_W-1:0] out_rdata;

  tsq_lifo #(.DEPTH(DEPTH)) u_inbox (
    .clk     (clk),
    .rst     (rst),
    .req     (in_req),
    .wr_data (in_wdata),
    .rd_data (in_rdata),
    .stat    (in_stat)
  );

  // The outbox is fed straight from the inbox read port during a move.
  tsq_lifo #(.DEPTH(DEPTH)) u_outbox (
    .clk     (clk),
    .rst     (rst),
    .req     (out_req),
    .wr_data (in_rdata),
    .rd_data (out_rdata),
    .stat    (out_stat)
  );

  tsq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .in_req    (in_req),
    .in_wdata  (in_wdata),
    .in_stat   (in_stat),
    .out_req   (out_req),
    .out_stat  (out_stat),
    .out_rdata (out_rdata)
  );

endmodule

### hdl/tsq_checker.sv
module tsq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [tsq_pkg::WORD_W-1:0]    m_tdata,
  input logic [tsq_pkg::STATUS_W-1:0]  m_tuser
);

  // No result may be pending right after reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Every request passes through further states, so ready must drop after a request.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready stayed high after a request");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == tsq_pkg::ST_OK || m_tuser == tsq_pkg::ST_FULL ||
                  m_tuser == tsq_pkg::ST_EMPTY))
    else $error("undefined status code");

  // A dropped push or an empty pop returns no data.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != tsq_pkg::ST_OK) |-> (m_tdata == '0))
    else $error("nonzero data with error status");

endmodule

bind two_stack_queue tsq_checker u_tsq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
